@@ rtl/f2da_pkg.sv @@
package f2da_pkg;

  // field widths
  localparam int FLOAT_W   = 32;
  localparam int CHAR_W    = 7;
  localparam int CFG_W     = 4;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  // number format
  localparam int MANT_W    = 24;
  localparam int INT_BITS  = 31;
  localparam int FRAC_BITS = 24;
  localparam int INT_DIGITS = 10;
  localparam int FRAC_MAX  = 15;
  localparam int DIGIT_W   = 4;
  localparam int EXP_BIAS  = 127;
  localparam int EXP_LIMIT = 31;
  localparam int EXP_MIN   = -23;

  // biased exponent window that converts
  localparam logic [7:0] EXP_FIELD_MIN = 8'(EXP_BIAS + EXP_MIN);
  localparam logic [7:0] EXP_FIELD_MAX = 8'(EXP_BIAS + EXP_LIMIT - 1);

  // ascii codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_NONE  = 7'h00;

  // register map, indexed by paddr[2]
  localparam logic REG_FRAC_DIGITS = 1'b0;
  localparam logic [CFG_W-1:0] FRAC_DIGITS_RESET = 4'd6;

  typedef logic [INT_DIGITS*DIGIT_W-1:0] bcd_t;
  typedef logic [FRAC_MAX*DIGIT_W-1:0]   frac_buf_t;

endpackage

@@ rtl/float_to_decimal_ascii.sv @@
// float_to_decimal_ascii: IEEE single bit pattern in, decimal ascii text out.
// input channel: in_valid / in_ready with float_bits, one number per item.
// output channel: out_valid / out_ready, one character per item, with last on
// the final character and error on the single result of an out-of-range
// exponent (char_code 0, last 1).
// an item is converted in three phases: a load, a bit-serial binary-to-bcd
// shift of 31 steps (the fraction digits are formed by a x10 step in the
// first 15 of them), then dropping leading zero digits. characters then
// leave at one per cycle while out_ready is high.
// in_ready is high only between numbers; a held output character stalls the
// character stream, and the last character may wait while the next number
// is accepted.
// frac_digits sits at byte address 0 of the apb port, reset value 6.
// reset returns the sequencer to idle, clears out_valid and sets frac_digits to 6.
module float_to_decimal_ascii #(
  parameter int BUFFER_CHARS = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [f2da_pkg::FLOAT_W-1:0]  float_bits,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [f2da_pkg::CHAR_W-1:0]   char_code,
  output logic                          last,
  output logic                          error,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [f2da_pkg::APB_AW-1:0]   paddr,
  input  logic [f2da_pkg::APB_DW-1:0]   pwdata,
  output logic [f2da_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import f2da_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_NORM  = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_INT   = 3'd4;
  localparam logic [2:0] S_POINT = 3'd5;
  localparam logic [2:0] S_FRAC  = 3'd6;
  localparam logic [2:0] S_ERR   = 3'd7;

  localparam int          WIDE_W    = MANT_W + INT_BITS;
  localparam logic [4:0]  STEP_LAST = 5'(INT_BITS - 1);
  localparam logic [4:0]  STEP_FRAC = 5'(FRAC_MAX);
  localparam logic [5:0]  ROOM_BASE = 6'(BUFFER_CHARS - 1);

  logic [2:0]                state;
  logic [4:0]                step;
  logic [INT_BITS-1:0]       ibits;
  bcd_t                      bcd;
  logic [FRAC_BITS-1:0]      frac;
  frac_buf_t                 fdig;
  logic [FRAC_MAX-1:0]       nz;
  logic                      neg;
  logic                      fzero;
  logic [3:0]                nd;
  logic [3:0]                fcnt;
  logic [CFG_W-1:0]          frac_digits;

  logic                      emit_go;
  logic                      load_out;
  logic                      cfg_wr;
  logic [7:0]                exp_field;
  logic                      is_zero;
  logic                      exp_bad;
  logic [5:0]                shamt;
  logic [WIDE_W-1:0]         wide;
  bcd_t                      bcd_adj;
  logic [FRAC_BITS+3:0]      prod;
  logic [DIGIT_W-1:0]        fdigit;
  logic [5:0]                pre_len;
  logic [5:0]                room;
  logic [3:0]                cnt;
  logic [3:0]                nlen;
  logic [3:0]                nfrac;
  logic                      int_lead_zero;

  assign in_ready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign emit_go  = !out_valid || out_ready;
  assign load_out = emit_go && (state inside {S_SIGN, S_INT, S_POINT, S_FRAC, S_ERR});
  assign cfg_wr   = psel && penable && pwrite && pready;

  // register read
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FRAC_DIGITS) begin
      prdata = {{(APB_DW-CFG_W){1'b0}}, frac_digits};
    end
  end

  // decode of the incoming bit pattern into a fixed point word
  always_comb begin
    exp_field = float_bits[30:23];
    is_zero   = (float_bits[30:0] == '0);
    exp_bad   = !is_zero && ((exp_field < EXP_FIELD_MIN) || (exp_field > EXP_FIELD_MAX));
    shamt     = 6'(EXP_FIELD_MAX - exp_field);
    wide      = {1'b1, float_bits[22:0], {INT_BITS{1'b0}}} >> shamt;
  end

  // add-3 correction of each bcd digit
  always_comb begin
    for (int d = 0; d < INT_DIGITS; d++) begin
      bcd_adj[d*DIGIT_W +: DIGIT_W] = (bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5) ?
        bcd[d*DIGIT_W +: DIGIT_W] + 4'd3 : bcd[d*DIGIT_W +: DIGIT_W];
    end
  end

  // fraction times ten, integer digit on top
  assign prod   = (FRAC_BITS+4)'({frac, 3'b000}) + (FRAC_BITS+4)'({frac, 1'b0});
  assign fdigit = prod[FRAC_BITS+3:FRAC_BITS];

  assign int_lead_zero = (bcd[INT_DIGITS*DIGIT_W-1 -: DIGIT_W] == '0);

  // fraction digits that fit, trailing zeros stripped
  always_comb begin
    pre_len = 6'(neg) + 6'(nd) + 6'd1;
    room    = (ROOM_BASE > pre_len) ? ROOM_BASE - pre_len : '0;
    cnt     = (6'(frac_digits) < room) ? frac_digits : room[3:0];
    nlen    = '0;
    for (int i = 0; i < FRAC_MAX; i++) begin
      if ((4'(i) < cnt) && nz[i]) begin
        nlen = 4'(i + 1);
      end
    end
    if (fzero) begin
      nfrac = 4'd1;
    end else if (cnt == '0) begin
      nfrac = '0;
    end else if (nlen == '0) begin
      nfrac = 4'd1;
    end else begin
      nfrac = nlen;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frac_digits <= FRAC_DIGITS_RESET;
    end else if (cfg_wr && (paddr[2] == REG_FRAC_DIGITS)) begin
      frac_digits <= pwdata[CFG_W-1:0];
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            neg   <= float_bits[31] && !is_zero;
            ibits <= is_zero ? '0 : wide[WIDE_W-1:FRAC_BITS];
            frac  <= is_zero ? '0 : wide[FRAC_BITS-1:0];
            fzero <= is_zero || (wide[FRAC_BITS-1:0] == '0);
            bcd   <= '0;
            step  <= '0;
            nd    <= 4'(INT_DIGITS);
            state <= exp_bad ? S_ERR : S_CONV;
          end
        end
        S_CONV: begin
          bcd   <= {bcd_adj[INT_DIGITS*DIGIT_W-2:0], ibits[INT_BITS-1]};
          ibits <= {ibits[INT_BITS-2:0], 1'b0};
          if (step < STEP_FRAC) begin
            frac           <= prod[FRAC_BITS-1:0];
            fdig           <= {fdig[(FRAC_MAX-1)*DIGIT_W-1:0], fdigit};
            nz[step[3:0]]  <= (fdigit != '0);
          end
          if (step == STEP_LAST) begin
            state <= S_NORM;
          end else begin
            step <= step + 5'd1;
          end
        end
        S_NORM: begin
          if (int_lead_zero && (nd > 4'd1)) begin
            bcd <= {bcd[(INT_DIGITS-1)*DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            nd  <= nd - 4'd1;
          end else begin
            fcnt  <= nfrac;
            state <= neg ? S_SIGN : S_INT;
          end
        end
        S_SIGN: begin
          if (emit_go) begin
            char_code <= CH_MINUS;
            last      <= 1'b0;
            error     <= 1'b0;
            state     <= S_INT;
          end
        end
        S_INT: begin
          if (emit_go) begin
            char_code <= CH_ZERO + 7'(bcd[INT_DIGITS*DIGIT_W-1 -: DIGIT_W]);
            last      <= 1'b0;
            error     <= 1'b0;
            bcd       <= {bcd[(INT_DIGITS-1)*DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            nd        <= nd - 4'd1;
            if (nd == 4'd1) begin
              state <= S_POINT;
            end
          end
        end
        S_POINT: begin
          if (emit_go) begin
            char_code <= CH_POINT;
            last      <= (fcnt == '0);
            error     <= 1'b0;
            state     <= (fcnt == '0) ? S_IDLE : S_FRAC;
          end
        end
        S_FRAC: begin
          if (emit_go) begin
            char_code <= CH_ZERO + 7'(fdig[FRAC_MAX*DIGIT_W-1 -: DIGIT_W]);
            last      <= (fcnt == 4'd1);
            error     <= 1'b0;
            fdig      <= {fdig[(FRAC_MAX-1)*DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            fcnt      <= fcnt - 4'd1;
            if (fcnt == 4'd1) begin
              state <= S_IDLE;
            end
          end
        end
        S_ERR: begin
          if (emit_go) begin
            char_code <= CH_NONE;
            last      <= 1'b1;
            error     <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // error item is a single zero character
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (last && (char_code == CH_NONE)))
    else $error("error item not a lone terminal character");

  // ordinary items are digits, minus or point
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !error) |-> (((char_code >= CH_ZERO) && (char_code <= CH_NINE)) ||
      (char_code == CH_MINUS) || (char_code == CH_POINT)))
    else $error("unexpected character code");

  // the bcd shift runs its full length then drops leading zeros
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_CONV) && (step == STEP_LAST)) |=> (state == S_NORM))
    else $error("bcd conversion did not finish");

  // integer digit count never runs out while emitting
  assert property (@(posedge clk) disable iff (rst)
    (state == S_INT) |-> (nd != '0))
    else $error("integer digit count underflow");

endmodule
